// ===== hw/rtl/fir_filter_centered_core_defines.svh =====
// Assertion macros shared by the FIR core RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef FIR_FILTER_CENTERED_CORE_DEFINES_SVH
`define FIR_FILTER_CENTERED_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on an explicit clock and reset
`define FCC_ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property on the module's clock and reset
`define FCC_ASSERT(lbl, prop, msg) `FCC_ASSERT_CLK(lbl, clock, reset, prop, msg)
`else
`define FCC_ASSERT_CLK(lbl, clk, rst, prop, msg)
`define FCC_ASSERT(lbl, prop, msg)
`endif

`endif

// ===== hw/rtl/fir_cen_pkg.sv =====
// Shared types and constants for the centered FIR core.
// No dependencies; imported by the register file, controller, datapath and top.
`default_nettype none

package fir_cen_pkg;

   // Sample and coefficient formats
   localparam int SAMPLE_W   = 16;
   localparam int COEF_W     = 16;
   localparam int COEF_NUM   = 16;
   localparam int COEF_IDX_W = 4;
   localparam int FRAC_BITS  = 15;
   localparam int TAPCNT_W   = 5;

   // Record position counter saturates here
   localparam int SEEN_W = 5;
   localparam logic [SEEN_W-1:0] SEEN_MAX = '1;

   // Saturation limits of the result
   localparam logic signed [SAMPLE_W-1:0] SAT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] SAT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

   // Register port geometry: 64-bit registers at 8-byte strides
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int COEF_REGS  = 4;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_TAP_COUNT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CENTERED   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_0_3   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_4_7   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_8_11  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_12_15 = 3'd5;

   // Reset value of the first coefficient register
   localparam logic [CSR_DATA_W-1:0] COEF_0_3_RESET = 64'd32767;

   // Configuration seen by the datapath
   typedef struct packed {
      logic [TAPCNT_W-1:0]                tap_count;
      logic                               centered;
      logic [COEF_NUM-1:0][COEF_W-1:0]    coef;
   } cfg_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;          // take the request sample into the delay line
      logic shift_zero;    // shift a flush zero into the delay line
      logic acc_clear;     // start a new multiply-accumulate pass
      logic mac_issue;     // multiply one tap
      logic emit;          // load the result register
      logic clear_record;  // return delay line and position to zero
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic emit_ok;    // current position gives an output
      logic last;       // current record ends with this request
      logic final_out;  // the pending output is the last of the record
      logic mac_done;   // the tap being issued is the last in use
      logic out_free;   // result register can take a new value
   } sts_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_MAC,
      ST_DRAIN,
      ST_EMIT,
      ST_FLUSH
   } fsm_state_type;

endpackage

`default_nettype wire

// ===== hw/rtl/fir_filter_centered_core.sv =====
// FIR filter over sample records, causal or centered (zero-delay) mode.
// Requests: req_sample with req_end_of_record on the last sample of a record,
// valid/ready handshake. Results: rsp_filtered with rsp_final_result on the
// last output of a record, valid/ready handshake. Registers through an
// APB-style port: tap count, mode and sixteen Q1.15 coefficients.
// One multiplier serves all taps: an output passes through accept, decide,
// one tap per cycle, drain and emit; a request that gives no output passes
// through accept and decide only. A flush zero of a centered record passes
// through shift and decide, then the taps, drain and emit if it gives an output.
// A request is taken only while the sequencer is idle, which it may be even
// while a finished result still waits in the result register.
// A centered record's last request is followed by (taps in use)/2 flush zeros,
// rounded down; each record yields as many results as requests.
// If the receiver stalls, the result register holds and the sequencer waits
// before writing the next result. Reset (synchronous) clears the delay line,
// the record position and the result valid flag, and sets one tap of 32767.
// Depends on fir_cen_pkg, fir_cen_csr, fir_cen_ctrl and fir_cen_dp.
`default_nettype none

module fir_filter_centered_core
   import fir_cen_pkg::*;
#(
   parameter int MAX_TAPS = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic signed [SAMPLE_W-1:0]  req_sample,
   input  wire logic                        req_end_of_record,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic signed      [SAMPLE_W-1:0]  rsp_filtered,
   output logic                             rsp_final_result,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [CSR_ADDR_W-1:0]       paddr,
   input  wire logic [CSR_DATA_W-1:0]       pwdata,
   output logic      [CSR_DATA_W-1:0]       prdata,
   output logic                             pready
);

   cfg_type cfg;
   cmd_type cmd;
   sts_type sts;

   fir_cen_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   fir_cen_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   fir_cen_dp #(
      .MAX_TAPS (MAX_TAPS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .cmd               (cmd),
      .sts               (sts),
      .req_sample        (req_sample),
      .req_end_of_record (req_end_of_record),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_filtered      (rsp_filtered),
      .rsp_final_result  (rsp_final_result)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/fir_cen_csr.sv =====
// Configuration register file of the centered FIR core (APB-style port).
// Depends on fir_cen_pkg.
`default_nettype none

module fir_cen_csr
   import fir_cen_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready,
   output cfg_type                    cfg
);

   logic [TAPCNT_W-1:0]                   tap_count_ff, tap_count_in;
   logic                                  centered_ff, centered_in;
   logic [COEF_REGS-1:0][CSR_DATA_W-1:0]  coef_ff, coef_in;
   logic [CSR_IDX_W-1:0]                  csr_idx;
   logic                                  wr_en;

   assign pready  = 1'b1;
   assign csr_idx = paddr[CSR_ADDR_W-1:CSR_ADDR_W-CSR_IDX_W];
   assign wr_en   = psel & penable & pwrite;

   // Decode writes
   always_comb begin
      tap_count_in = tap_count_ff;
      centered_in  = centered_ff;
      coef_in      = coef_ff;
      if (wr_en) begin
         unique case (csr_idx)
            REG_TAP_COUNT:  tap_count_in = pwdata[TAPCNT_W-1:0];
            REG_CENTERED:   centered_in  = pwdata[0];
            REG_COEF_0_3:   coef_in[0]   = pwdata;
            REG_COEF_4_7:   coef_in[1]   = pwdata;
            REG_COEF_8_11:  coef_in[2]   = pwdata;
            REG_COEF_12_15: coef_in[3]   = pwdata;
            default: ;
         endcase
      end
   end

   // Hold register values
   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= TAPCNT_W'(1);
         centered_ff  <= 1'b0;
         coef_ff      <= {{((COEF_REGS-1)*CSR_DATA_W){1'b0}}, COEF_0_3_RESET};
      end else begin
         tap_count_ff <= tap_count_in;
         centered_ff  <= centered_in;
         coef_ff      <= coef_in;
      end
   end

   // Read back
   always_comb begin
      unique case (csr_idx)
         REG_TAP_COUNT:  prdata = CSR_DATA_W'(tap_count_ff);
         REG_CENTERED:   prdata = CSR_DATA_W'(centered_ff);
         REG_COEF_0_3:   prdata = coef_ff[0];
         REG_COEF_4_7:   prdata = coef_ff[1];
         REG_COEF_8_11:  prdata = coef_ff[2];
         REG_COEF_12_15: prdata = coef_ff[3];
         default:        prdata = '0;
      endcase
   end

   // Coefficient k sits in register k/4, bits 16*(k%4) upward
   assign cfg.tap_count = tap_count_ff;
   assign cfg.centered  = centered_ff;
   assign cfg.coef      = coef_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/fir_cen_ctrl.sv =====
// Sequencing state machine of the centered FIR core.
// Depends on fir_cen_pkg; drives commands into fir_cen_dp and reads its status.
`default_nettype none

module fir_cen_ctrl
   import fir_cen_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   fsm_state_type state_ff, state_in;

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            priority if (sts.emit_ok) begin
               cmd.acc_clear = 1'b1;
               state_in      = ST_MAC;
            end else if (sts.last) begin
               state_in = ST_FLUSH;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_MAC: begin
            cmd.mac_issue = 1'b1;
            if (sts.mac_done) begin
               state_in = ST_DRAIN;
            end
         end
         // let the last product reach the accumulator
         ST_DRAIN: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               priority if (sts.final_out) begin
                  cmd.clear_record = 1'b1;
                  state_in         = ST_IDLE;
               end else if (sts.last) begin
                  state_in = ST_FLUSH;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_FLUSH: begin
            cmd.shift_zero = 1'b1;
            state_in       = ST_DECIDE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== hw/rtl/fir_cen_dp.sv =====
// Datapath of the centered FIR core: delay line, shared multiply-accumulate,
// rounding and saturation, result register. Depends on fir_cen_pkg and the defines.
`default_nettype none
`include "fir_filter_centered_core_defines.svh"

module fir_cen_dp
   import fir_cen_pkg::*;
#(
   parameter int MAX_TAPS = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire cfg_type                     cfg,
   input  wire cmd_type                     cmd,
   output sts_type                          sts,
   input  wire logic signed [SAMPLE_W-1:0]  req_sample,
   input  wire logic                        req_end_of_record,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic signed      [SAMPLE_W-1:0]  rsp_filtered,
   output logic                             rsp_final_result
);

   localparam int TAP_W  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int CNT_W  = $clog2(MAX_TAPS + 1);
   localparam int PROD_W = SAMPLE_W + COEF_W;
   localparam int ACC_W  = PROD_W + TAP_W;
   localparam int POS_W  = SEEN_W + 1;
   localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) << (FRAC_BITS - 1);

   logic [CNT_W-1:0] taps;
   logic [TAP_W-1:0] last_tap;
   logic [TAP_W-1:0] offset;

   logic signed [SAMPLE_W-1:0] dl_ff [MAX_TAPS];
   logic signed [SAMPLE_W-1:0] dl_in [MAX_TAPS];
   logic [SEEN_W-1:0]          seen_ff, seen_in;
   logic [SEEN_W-1:0]          pos_ff, pos_in;
   logic [TAP_W-1:0]           fl_ff, fl_in;
   logic                       last_ff, last_in;
   logic [TAP_W-1:0]           k_ff, k_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic                       prod_vld_ff, prod_vld_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [COEF_W-1:0]   coef_sel;
   logic signed [ACC_W-1:0]    rnd;
   logic signed [SAMPLE_W-1:0] sat_val;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_data_ff, rsp_data_in;
   logic                       rsp_final_ff, rsp_final_in;

   // Clamp the tap count into 1..MAX_TAPS; centered mode delays by half of it
   always_comb begin
      priority if (cfg.tap_count == '0) begin
         taps = CNT_W'(1);
      end else if (cfg.tap_count > MAX_TAPS) begin
         taps = CNT_W'(MAX_TAPS);
      end else begin
         taps = CNT_W'(cfg.tap_count);
      end
   end
   assign last_tap = TAP_W'(taps - CNT_W'(1));
   assign offset   = cfg.centered ? TAP_W'(taps >> 1) : '0;

   // Shift the delay line, newest sample at entry zero
   always_comb begin
      dl_in = dl_ff;
      priority if (cmd.clear_record) begin
         for (int i = 0; i < MAX_TAPS; i++) begin
            dl_in[i] = '0;
         end
      end else if (cmd.load || cmd.shift_zero) begin
         dl_in[0] = cmd.load ? req_sample : '0;
         for (int i = 1; i < MAX_TAPS; i++) begin
            dl_in[i] = dl_ff[i-1];
         end
      end
   end

   // Track the record position, flush count and end flag
   always_comb begin
      seen_in = seen_ff;
      pos_in  = pos_ff;
      fl_in   = fl_ff;
      last_in = last_ff;
      priority if (cmd.clear_record) begin
         seen_in = '0;
      end else if (cmd.load) begin
         pos_in  = seen_ff;
         fl_in   = '0;
         last_in = req_end_of_record;
         if (seen_ff != SEEN_MAX) begin
            seen_in = seen_ff + SEEN_W'(1);
         end
      end else if (cmd.shift_zero) begin
         fl_in = fl_ff + TAP_W'(1);
      end
   end

   // Multiply one tap per cycle; the product is registered before it is accumulated
   assign coef_sel    = $signed(cfg.coef[COEF_IDX_W'(k_ff)]);
   assign prod_in     = cmd.mac_issue ? coef_sel * dl_ff[k_ff] : prod_ff;
   assign prod_vld_in = cmd.mac_issue & ~cmd.acc_clear;

   always_comb begin
      k_in   = k_ff;
      acc_in = acc_ff;
      priority if (cmd.acc_clear) begin
         k_in   = '0;
         acc_in = '0;
      end else begin
         if (cmd.mac_issue) begin
            k_in = k_ff + TAP_W'(1);
         end
         if (prod_vld_ff) begin
            acc_in = acc_ff + ACC_W'(prod_ff);
         end
      end
   end

   // Round half up, drop the fraction, saturate to the sample range
   assign rnd = acc_ff + ROUND_BIAS;
   always_comb begin
      priority if ((&rnd[ACC_W-1:FRAC_BITS+SAMPLE_W-1]) ||
                   (~|rnd[ACC_W-1:FRAC_BITS+SAMPLE_W-1])) begin
         sat_val = rnd[FRAC_BITS+SAMPLE_W-1:FRAC_BITS];
      end else if (rnd[ACC_W-1]) begin
         sat_val = SAT_MIN;
      end else begin
         sat_val = SAT_MAX;
      end
   end

   // Result register: load on emit, drop valid once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_final_in = rsp_final_ff;
      priority if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = sat_val;
         rsp_final_in = sts.final_out;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_TAPS; i++) begin
            dl_ff[i] <= '0;
         end
         seen_ff      <= '0;
         fl_ff        <= '0;
         last_ff      <= 1'b0;
         k_ff         <= '0;
         prod_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         dl_ff        <= dl_in;
         seen_ff      <= seen_in;
         fl_ff        <= fl_in;
         last_ff      <= last_in;
         k_ff         <= k_in;
         prod_vld_ff  <= prod_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_final_ff <= rsp_final_in;
   end

   // Status to the controller
   assign sts.emit_ok   = (POS_W'(pos_ff) + POS_W'(fl_ff)) >= POS_W'(offset);
   assign sts.last      = last_ff;
   assign sts.final_out = last_ff && (fl_ff == offset);
   assign sts.mac_done  = (k_ff == last_tap);
   assign sts.out_free  = ~rsp_valid_ff | rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_filtered     = rsp_data_ff;
   assign rsp_final_result = rsp_final_ff;

   `FCC_ASSERT(a_tap_in_range, cmd.mac_issue |-> (k_ff <= last_tap), "tap index past last tap")
   `FCC_ASSERT(a_flush_bound, cmd.shift_zero |-> (fl_ff < offset), "flush ran past half taps")
   `FCC_ASSERT(a_record_clear, cmd.clear_record |=> (seen_ff == '0) && (dl_ff[0] == '0), "record state not cleared")
   `FCC_ASSERT(a_emit_free, cmd.emit |-> sts.out_free, "result overwritten while stalled")

endmodule

`default_nettype wire
